>>> hdl/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// shared types and constants of the snapshot visibility check unit
// ----------------------------------------------------------------------------
package svc_pkg;

   localparam int ID_W      = 63;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_HORIZON = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_HORIZON = 1'b1;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } state_type;

   typedef struct packed {
      logic       visible;
      status_type status;
   } rsp_type;

endpackage

>>> hdl/svc_id_mem.sv
// ----------------------------------------------------------------------------
// svc_id_mem
// id list storage, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module svc_id_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [svc_pkg::ID_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [svc_pkg::ID_W-1:0] rd_data
);
   import svc_pkg::*;

   logic [ID_W-1:0] mem_ff [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/svc_ctrl.sv
// ----------------------------------------------------------------------------
// svc_ctrl
// command sequencer: append checks, horizon tests and binary search
// ----------------------------------------------------------------------------
module svc_ctrl #(
   parameter int MAX_IDS = 64,
   parameter int ADDR_W  = 6,
   parameter int CNT_W   = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [svc_pkg::CMD_W-1:0]    command,
   input  logic [svc_pkg::ID_W-1:0]     txn_id,
   input  logic [svc_pkg::ID_W-1:0]     lower_horizon,
   input  logic [svc_pkg::ID_W-1:0]     upper_horizon,
   output logic                         busy,
   output logic                         rsp_strobe,
   output svc_pkg::rsp_type             rsp,
   output logic                         mem_wr_en,
   output logic [ADDR_W-1:0]            mem_wr_addr,
   output logic [svc_pkg::ID_W-1:0]     mem_wr_data,
   output logic                         mem_rd_en,
   output logic [ADDR_W-1:0]            mem_rd_addr,
   input  logic [svc_pkg::ID_W-1:0]     mem_rd_data
);
   import svc_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]  last_ff, last_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic [ID_W-1:0]  last_id;
   logic [CNT_W:0]   mid_sum;
   logic             accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      id_ff   <= id_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      rsp_ff  <= rsp_in;
   end

   assign accept  = start && (state_ff == S_IDLE);
   assign last_id = (count_ff == '0) ? '0 : last_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      id_in       = id_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[ADDR_W-1:0];
      mem_wr_data = txn_id;
      mem_rd_en   = 1'b0;
      mem_rd_addr = mid_ff[ADDR_W-1:0];
      mid_sum     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               strobe_in      = 1'b1;
               rsp_in.visible = 1'b0;
               rsp_in.status  = ST_OK;
               case (command)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (count_ff >= MAX_CNT) begin
                        rsp_in.status = ST_FULL;
                     end else if (txn_id < lower_horizon || txn_id >= upper_horizon ||
                                  txn_id <= last_id) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        last_in   = txn_id;
                     end
                  end
                  CMD_QUERY: begin
                     if (txn_id < lower_horizon) begin
                        rsp_in.visible = 1'b1;
                     end else if (txn_id >= upper_horizon) begin
                        rsp_in.visible = 1'b0;
                     end else if (count_ff == '0) begin
                        rsp_in.visible = 1'b1;
                     end else begin
                        // start the search over the whole list
                        strobe_in   = 1'b0;
                        id_in       = txn_id;
                        lo_in       = '0;
                        hi_in       = count_ff;
                        mid_in      = count_ff >> 1;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = mid_in[ADDR_W-1:0];
                        state_in    = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            rsp_in.status = ST_OK;
            if (mem_rd_data == id_ff) begin
               strobe_in      = 1'b1;
               rsp_in.visible = 1'b0;
               state_in       = S_IDLE;
            end else begin
               if (mem_rd_data < id_ff) begin
                  lo_in = mid_ff + CNT_W'(1);
               end else begin
                  hi_in = mid_ff;
               end
               if (lo_in < hi_in) begin
                  mid_sum     = {1'b0, lo_in} + {1'b0, hi_in};
                  mid_in      = mid_sum[CNT_W:1];
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = mid_in[ADDR_W-1:0];
               end else begin
                  strobe_in      = 1'b1;
                  rsp_in.visible = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

>>> hdl/snapshot_visibility_check_unit.sv
// ----------------------------------------------------------------------------
// snapshot_visibility_check_unit
// snapshot visibility check over a sorted list of in-progress ids
//
//   channel   ports                                        transfer
//   request   start, busy, req_command, req_txn_id         start high, busy low
//   response  rsp_strobe, rsp_visible, rsp_status          rsp_strobe high
//   config    csr_write_enable, csr_index, csr_write_data  csr_write_enable high
//
// clear and append: result in the cycle after the transfer, busy stays low
// query settled by the horizons or an empty list: result in the cycle after the transfer
// other queries: binary search, one id memory read per step, busy high meanwhile
// reset clears the entry count and horizons; the id memory is not cleared
// the receiver cannot stall; a result shows for exactly one cycle
// ----------------------------------------------------------------------------
module snapshot_visibility_check_unit #(
   parameter int MAX_IDS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [svc_pkg::CMD_W-1:0]        req_command,
   input  logic [svc_pkg::ID_W-1:0]         req_txn_id,
   output logic                             rsp_strobe,
   output logic                             rsp_visible,
   output logic [svc_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_write_enable,
   input  logic [svc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [svc_pkg::ID_W-1:0]         csr_write_data
);
   import svc_pkg::*;

   localparam int ADDR_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
   localparam int CNT_W  = $clog2(MAX_IDS + 1);

   logic [ID_W-1:0]   lower_horizon_ff;
   logic [ID_W-1:0]   upper_horizon_ff;
   rsp_type           rsp;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [ID_W-1:0]   mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [ID_W-1:0]   mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_horizon_ff <= '0;
         upper_horizon_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOWER_HORIZON: lower_horizon_ff <= csr_write_data;
            CSR_UPPER_HORIZON: upper_horizon_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   svc_ctrl #(
      .MAX_IDS (MAX_IDS),
      .ADDR_W  (ADDR_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .command       (req_command),
      .txn_id        (req_txn_id),
      .lower_horizon (lower_horizon_ff),
      .upper_horizon (upper_horizon_ff),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp           (rsp),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   svc_id_mem #(
      .DEPTH  (MAX_IDS),
      .ADDR_W (ADDR_W)
   ) u_id_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_visible = rsp.visible;
   assign rsp_status  = rsp.status;

endmodule

>>> hdl/svc_checker.sv
// ----------------------------------------------------------------------------
// svc_checker
// port-level checks of the snapshot visibility check unit
// ----------------------------------------------------------------------------
module svc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [svc_pkg::CMD_W-1:0]        req_command,
   input logic [svc_pkg::ID_W-1:0]         req_txn_id,
   input logic                             rsp_strobe,
   input logic                             rsp_visible,
   input logic [svc_pkg::STATUS_W-1:0]     rsp_status,
   input logic                             csr_write_enable,
   input logic [svc_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [svc_pkg::ID_W-1:0]         csr_write_data
);
   import svc_pkg::*;

   logic req_xfer;
   assign req_xfer = start && !busy;

   // clear, append and unknown commands answer on the next cycle, never visible
   a_direct_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_command != CMD_QUERY |=> rsp_strobe && !rsp_visible)
      else $error("no immediate result for non-query transfer");

   // a clear always succeeds
   a_clear_ok: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_command == CMD_CLEAR |=> rsp_status == ST_OK)
      else $error("clear reported an error");

   // a visible result comes only from a query, which reports ok
   a_visible_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_visible |-> rsp_status == ST_OK)
      else $error("visible result with error status");

   // busy only follows a transfer and ends with a result
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      busy && !$past(busy) |-> $past(req_xfer) && !rsp_strobe)
      else $error("busy without a query transfer");

   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $past(busy) && !busy && !$past(reset) |-> rsp_strobe)
      else $error("search ended without a result");

endmodule

bind snapshot_visibility_check_unit svc_checker u_svc_checker (.*);
